// File: design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths.
  localparam int OP_W     = 1;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int DATA_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int TAB_W    = 4;

  // Register port geometry.
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_LSB = 2;

  localparam logic [0:0] REG_ATTR = 1'b0;
  localparam logic [0:0] REG_TAB  = 1'b1;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd2;
  localparam logic [TAB_W-1:0]  TAB_RESET  = 4'd4;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OP_W-1:0] OP_READ = 1'b1;

  // Character codes with a special meaning.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [DATA_W-1:0]   read_data;
  } result_t;

  typedef struct packed {
    logic [ATTR_W-1:0] text_attribute;
    logic [TAB_W-1:0]  tab_width;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic read_issue;
    logic clear_step;
    logic clear_wrap;
    logic scroll_done;
    logic write_char;
    logic newline;
    logic back_step;
    logic bs_write;
    logic tab_reset;
    logic tab_inc;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic is_zero;
    logic is_newline;
    logic is_tab;
    logic is_bs;
    logic cursor_full;
    logic col_zero;
    logic tab_none;
    logic tab_last;
    logic clr_row_last;
    logic clr_all_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: design/tcw_regs.sv
`default_nettype none

module tcw_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcw_pkg::APB_AW-1:0] paddr,
  input  logic [tcw_pkg::APB_DW-1:0] pwdata,
  output logic [tcw_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output tcw_pkg::cfg_t              cfg
);
  import tcw_pkg::*;

  logic [0:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_LSB +: 1];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_attribute <= ATTR_RESET;
      cfg.tab_width      <= TAB_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTR: cfg.text_attribute <= pwdata[ATTR_W-1:0];
        REG_TAB:  cfg.tab_width      <= pwdata[TAB_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTR: prdata = APB_DW'(cfg.text_attribute);
      REG_TAB:  prdata = APB_DW'(cfg.tab_width);
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);
  import tcw_pkg::*;

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DISPATCH = 9'b000000100,
    S_CHECK    = 9'b000001000,
    S_SCROLL   = 9'b000010000,
    S_ACT      = 9'b000100000,
    S_BS_WRITE = 9'b001000000,
    S_RESULT   = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        // Sweep zeros through the whole screen after reset.
        cmd.clear_step = 1'b1;
        if (status.clr_all_last) begin
          cmd.clear_wrap = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.is_read) begin
          cmd.read_issue = 1'b1;
          state_next     = S_RESULT;
        end else if (status.is_zero) begin
          state_next = S_RESULT;
        end else begin
          cmd.tab_reset = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = status.cursor_full ? S_SCROLL : S_ACT;
      end
      S_SCROLL: begin
        // Clear the oldest row, then it becomes the bottom row.
        cmd.clear_step = 1'b1;
        if (status.clr_row_last) begin
          cmd.clear_wrap  = 1'b1;
          cmd.scroll_done = 1'b1;
          state_next      = S_ACT;
        end
      end
      S_ACT: begin
        if (status.is_newline) begin
          cmd.newline = 1'b1;
          state_next  = S_RESULT;
        end else if (status.is_bs) begin
          if (status.col_zero) begin
            state_next = S_RESULT;
          end else begin
            cmd.back_step = 1'b1;
            state_next    = S_BS_WRITE;
          end
        end else if (status.is_tab) begin
          if (status.tab_none) begin
            state_next = S_RESULT;
          end else begin
            cmd.write_char = 1'b1;
            cmd.tab_inc    = 1'b1;
            state_next     = status.tab_last ? S_RESULT : S_CHECK;
          end
        end else begin
          cmd.write_char = 1'b1;
          state_next     = S_RESULT;
        end
      end
      S_BS_WRITE: begin
        cmd.bs_write = 1'b1;
        state_next   = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/tcw_dp.sv
`default_nettype none

module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  tcw_pkg::cmd_t     cmd,
  output tcw_pkg::status_t  status,
  input  tcw_pkg::cfg_t     cfg,
  input  tcw_pkg::item_t    item,
  output tcw_pkg::result_t  result,
  output logic              result_valid,
  input  logic              result_stall
);
  import tcw_pkg::*;

  localparam int CellCount = COLUMNS * ROWS;
  localparam int CellW     = $clog2(CellCount);
  localparam int CurW      = $clog2(CellCount + 1);
  localparam int ColW      = $clog2(COLUMNS);
  localparam int SumW      = CellW + 1;
  localparam int IdxCmpW   = (INDEX_W > CurW) ? INDEX_W : CurW;

  localparam logic [CurW-1:0]    CUR_END      = CurW'(CellCount);
  localparam logic [CurW-1:0]    CUR_LAST_ROW = CurW'(CellCount - COLUMNS);
  localparam logic [CurW-1:0]    CUR_ROW_LEN  = CurW'(COLUMNS);
  localparam logic [CellW-1:0]   BASE_LAST    = CellW'(CellCount - COLUMNS);
  localparam logic [CellW-1:0]   ROW_STEP     = CellW'(COLUMNS);
  localparam logic [SumW-1:0]    SUM_WRAP     = SumW'(CellCount);
  localparam logic [ColW-1:0]    COL_LAST     = ColW'(COLUMNS - 1);
  localparam logic [CellW-1:0]   CLR_ROW_LAST = CellW'(COLUMNS - 1);
  localparam logic [CellW-1:0]   CLR_ALL_LAST = CellW'(CellCount - 1);
  localparam logic [IdxCmpW-1:0] IDX_LIMIT    = IdxCmpW'(CellCount);

  // Rows are stored rotated: logical row 0 starts at physical cell top_base.
  function automatic logic [CellW-1:0] to_phys(input logic [CellW-1:0] lcell,
                                               input logic [CellW-1:0] base);
    logic [SumW-1:0] s;
    s = {1'b0, lcell} + {1'b0, base};
    if (s >= SUM_WRAP) begin
      s = s - SUM_WRAP;
    end
    return s[CellW-1:0];
  endfunction

  item_t             item_q;
  logic [CurW-1:0]   cursor;
  logic [CurW-1:0]   cursor_next;
  logic [ColW-1:0]   col;
  logic [ColW-1:0]   col_next;
  logic [CellW-1:0]  top_base;
  logic [CellW-1:0]  top_base_next;
  logic [CellW-1:0]  clr_cnt;
  logic [CellW-1:0]  clr_cnt_next;
  logic [TAB_W-1:0]  tab_cnt;
  logic [TAB_W-1:0]  tab_cnt_next;
  logic [DATA_W-1:0] mem [CellCount];
  logic [DATA_W-1:0] rd_q;

  logic              idx_in_range;
  logic [CellW-1:0]  idx_cell;
  logic [CellW-1:0]  phys_idx;
  logic [CellW-1:0]  phys_cursor;
  logic [CellW-1:0]  clr_addr;
  logic [CHAR_W-1:0] wr_char;
  logic              wr_en;
  logic [CellW-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign idx_in_range = IdxCmpW'(item_q.cell_index) < IDX_LIMIT;
  assign idx_cell     = idx_in_range ? CellW'(item_q.cell_index) : '0;
  assign phys_idx     = to_phys(idx_cell, top_base);
  assign phys_cursor  = to_phys(cursor[CellW-1:0], top_base);
  assign clr_addr     = top_base + clr_cnt;

  always_comb begin
    if (cmd.bs_write || (item_q.char_code == CHAR_TAB)) begin
      wr_char = CHAR_SPACE;
    end else begin
      wr_char = item_q.char_code;
    end
    wr_en   = cmd.clear_step || cmd.write_char || cmd.bs_write;
    wr_addr = cmd.clear_step ? clr_addr : phys_cursor;
    wr_data = cmd.clear_step ? '0 : {cfg.text_attribute, wr_char};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read_issue) begin
      rd_q <= mem[phys_idx];
    end
  end

  always_comb begin
    cursor_next   = cursor;
    col_next      = col;
    top_base_next = top_base;
    clr_cnt_next  = clr_cnt;
    tab_cnt_next  = tab_cnt;
    if (cmd.scroll_done) begin
      top_base_next = (top_base == BASE_LAST) ? '0 : top_base + ROW_STEP;
      cursor_next   = CUR_LAST_ROW;
      col_next      = '0;
    end
    if (cmd.newline) begin
      cursor_next = cursor + (CUR_ROW_LEN - CurW'(col));
      col_next    = '0;
    end
    if (cmd.write_char) begin
      cursor_next = cursor + CurW'(1);
      col_next    = (col == COL_LAST) ? '0 : col + ColW'(1);
    end
    if (cmd.back_step) begin
      cursor_next = cursor - CurW'(1);
      col_next    = col - ColW'(1);
    end
    if (cmd.clear_wrap) begin
      clr_cnt_next = '0;
    end else if (cmd.clear_step) begin
      clr_cnt_next = clr_cnt + CellW'(1);
    end
    if (cmd.tab_reset) begin
      tab_cnt_next = '0;
    end else if (cmd.tab_inc) begin
      tab_cnt_next = tab_cnt + TAB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor       <= '0;
      col          <= '0;
      top_base     <= '0;
      clr_cnt      <= '0;
      tab_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      cursor   <= cursor_next;
      col      <= col_next;
      top_base <= top_base_next;
      clr_cnt  <= clr_cnt_next;
      tab_cnt  <= tab_cnt_next;
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q <= item;
    end
    if (cmd.load_result) begin
      result.cursor_position <= CURSOR_W'(cursor);
      if ((item_q.operation == OP_READ) && idx_in_range) begin
        result.read_data <= rd_q;
      end else begin
        result.read_data <= '0;
      end
    end
  end

  always_comb begin
    status.is_read      = (item_q.operation == OP_READ);
    status.is_zero      = (item_q.char_code == CHAR_NUL);
    status.is_newline   = (item_q.char_code == CHAR_LF);
    status.is_tab       = (item_q.char_code == CHAR_TAB);
    status.is_bs        = (item_q.char_code == CHAR_BS);
    status.cursor_full  = (cursor >= CUR_END);
    status.col_zero     = (col == '0);
    status.tab_none     = (tab_cnt == cfg.tab_width);
    status.tab_last     = (({1'b0, tab_cnt} + (TAB_W + 1)'(1)) == {1'b0, cfg.tab_width});
    status.clr_row_last = (clr_cnt == CLR_ROW_LAST);
    status.clr_all_last = (clr_cnt == CLR_ALL_LAST);
    status.out_free     = !result_valid || !result_stall;
  end

  // The cursor may sit one past the last cell, never further.
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= CUR_END)
    else $error("cursor beyond the end of the screen");

  // A cursor past the end always sits at a row start.
  a_full_at_row_start: assert property (@(posedge clk) disable iff (rst)
    (cursor >= CUR_END) |-> (col == '0))
    else $error("column out of step with a full cursor");

  // The single write port serves one requester per cycle.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.write_char, cmd.bs_write}))
    else $error("conflicting screen writes");

  // Characters are written only after the scroll check has made room.
  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.write_char || cmd.bs_write) |-> (cursor < CUR_END))
    else $error("character write with the cursor past the end");

endmodule

`default_nettype wire

// File: design/text_console_writer_core.sv
// A read or a zero byte goes straight to the result; a printable character, newline, backspace
// or tab first passes the scroll check, and a tab writes tab_width spaces, each checked again.
// Each scroll clears one row through the single screen write port.
// One transaction at a time; the next is accepted once the result is registered.
// Reset: synchronous; afterwards the screen is cleared one cell per cycle, all COLUMNS*ROWS
// cells (2000 by default), with item_stall high; register writes still work.
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  tcw_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output tcw_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcw_pkg::APB_AW-1:0] paddr,
  input  logic [tcw_pkg::APB_DW-1:0] pwdata,
  output logic [tcw_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import tcw_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  tcw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg          (cfg),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire
